### src/dmwc_pkg.sv
// Shared types, codes and default sizes for the direct-mapped write-back cache.
`timescale 1ns / 1ps

package dmwc_pkg;

  localparam int DCACHE_LINES_DEF = 512;
  localparam int ICACHE_LINES_DEF = 512;
  localparam int DLINE_BYTES_DEF  = 16;
  localparam int ILINE_BYTES_DEF  = 32;

  localparam int TAG_W  = 20;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 64;

  localparam logic [11:0] PAGE_OFF_MASK = 12'hFFF;

  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_FETCH = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_OP    = 3'd3;
  localparam logic [2:0] REQ_FILL  = 3'd4;

  localparam logic [2:0] RES_READ     = 3'd0;
  localparam logic [2:0] RES_WB_WORD  = 3'd1;
  localparam logic [2:0] RES_FILL_REQ = 3'd2;
  localparam logic [2:0] RES_TAG      = 3'd3;
  localparam logic [2:0] RES_DONE     = 3'd4;

  localparam logic [2:0] OP_INDEX_INV    = 3'd0;
  localparam logic [2:0] OP_LOAD_TAG     = 3'd1;
  localparam logic [2:0] OP_STORE_TAG    = 3'd2;
  localparam logic [2:0] OP_CREATE_DIRTY = 3'd3;
  localparam logic [2:0] OP_HIT_INV      = 3'd4;
  localparam logic [2:0] OP_HIT_WB_INV   = 3'd5;
  localparam logic [2:0] OP_HIT_WB       = 3'd6;

  localparam logic [1:0] SEL_ICACHE = 2'd0;
  localparam logic [1:0] SEL_DCACHE = 2'd1;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] phys_addr;
    logic [ADDR_W-1:0] virt_addr;
    logic [1:0]        access_size;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] wr_mask;
    logic              mask_enable;
    logic [1:0]        cache_select;
    logic [2:0]        cache_op;
    logic [TAG_W-1:0]  tag_value;
    logic [1:0]        tag_state;
  } req_t;

  typedef struct packed {
    logic              strobe;
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [TAG_W-1:0]  tag;
    logic [1:0]        state;
    logic              last;
  } res_t;

endpackage

### src/direct_mapped_writeback_cache_top.sv
// Top level of the direct-mapped write-back instruction and data cache pair.
//
// Requests are presented on the in_ ports with start high; a request is taken at a
// rising edge where start is high and busy is low. Results leave on the out_ ports,
// each valid for exactly one cycle while out_strobe is high, and out_last marks the
// final result of a request. The receiver cannot hold results off.
// Requests pass through a two-entry queue to the cache engine, which serves one
// request at a time. The queue head is popped in the idle state while the tag and
// data memories are read for it; the lookup state gives a hit's registered result
// and returns to idle for the next queued request.
// A data miss with a valid dirty victim first sends the victim's writeback words, each
// read from the single data memory read port and output in turn, before a fill request.
// The engine then waits for the fill words, taking one per cycle while one is queued;
// other requests that arrive while it waits are consumed without a result. After the
// last fill word the tag is written and the access is repeated through the issue and
// lookup states, or a maintenance operation completes with its done result.
// After reset the engine clears every tag, valid, dirty and data entry, one memory word
// a cycle in both caches until the larger one is done; busy stays high until then.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_top
  import dmwc_pkg::*;
#(
  parameter int DCACHE_LINES = DCACHE_LINES_DEF,
  parameter int ICACHE_LINES = ICACHE_LINES_DEF,
  parameter int DLINE_BYTES  = DLINE_BYTES_DEF,
  parameter int ILINE_BYTES  = ILINE_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_req_type,
  input  logic [ADDR_W-1:0]        in_phys_addr,
  input  logic [ADDR_W-1:0]        in_virt_addr,
  input  logic [1:0]               in_access_size,
  input  logic signed [DATA_W-1:0] in_wr_data,
  input  logic [DATA_W-1:0]        in_wr_mask,
  input  logic                     in_mask_enable,
  input  logic [1:0]               in_cache_select,
  input  logic [2:0]               in_cache_op,
  input  logic [TAG_W-1:0]         in_tag_value,
  input  logic [1:0]               in_tag_state,
  output logic                     out_strobe,
  output logic [2:0]               out_result_kind,
  output logic [ADDR_W-1:0]        out_mem_address,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [TAG_W-1:0]         out_tag_out,
  output logic [1:0]               out_tag_state_out,
  output logic                     out_last
);

  req_t in_req;
  req_t q_head;
  res_t res;
  logic q_valid;
  logic q_pop;
  logic clearing;

  assign in_req = '{req_type:     in_req_type,
                    phys_addr:    in_phys_addr,
                    virt_addr:    in_virt_addr,
                    access_size:  in_access_size,
                    wr_data:      in_wr_data,
                    wr_mask:      in_wr_mask,
                    mask_enable:  in_mask_enable,
                    cache_select: in_cache_select,
                    cache_op:     in_cache_op,
                    tag_value:    in_tag_value,
                    tag_state:    in_tag_state};

  dmwc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (in_req),
    .busy     (busy),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  dmwc_back #(
    .DCACHE_LINES (DCACHE_LINES),
    .ICACHE_LINES (ICACHE_LINES),
    .DLINE_BYTES  (DLINE_BYTES),
    .ILINE_BYTES  (ILINE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .res      (res)
  );

  assign out_strobe        = res.strobe;
  assign out_result_kind   = res.kind;
  assign out_mem_address   = res.addr;
  assign out_data_out      = res.data;
  assign out_tag_out       = res.tag;
  assign out_tag_state_out = res.state;
  assign out_last          = res.last;

endmodule

### src/dmwc_front.sv
// Request acceptance and the two-entry request queue in front of the cache engine.
`timescale 1ns / 1ps

module dmwc_front
  import dmwc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t req,
  output logic busy,
  input  logic clearing,
  output logic q_valid,
  output req_t q_head,
  input  logic q_pop
);

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  req_t             slot_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push;

  assign busy    = clearing || (count_r == QCW'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign q_head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/dmwc_back.sv
// Cache engine: line stores, lookup, maintenance operations, writeback and line fill.
`timescale 1ns / 1ps

module dmwc_back
  import dmwc_pkg::*;
#(
  parameter int DCACHE_LINES = DCACHE_LINES_DEF,
  parameter int ICACHE_LINES = ICACHE_LINES_DEF,
  parameter int DLINE_BYTES  = DLINE_BYTES_DEF,
  parameter int ILINE_BYTES  = ILINE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  req_t q_head,
  output logic q_pop,
  output logic clearing,
  output res_t res
);

  localparam int DWPL   = DLINE_BYTES / 8;
  localparam int IWPL   = ILINE_BYTES / 8;
  localparam int DWORDS = DCACHE_LINES * DWPL;
  localparam int IWORDS = ICACHE_LINES * IWPL;
  localparam int DLW    = $clog2(DCACHE_LINES);
  localparam int ILW    = $clog2(ICACHE_LINES);
  localparam int DOFFW  = $clog2(DLINE_BYTES);
  localparam int IOFFW  = $clog2(ILINE_BYTES);
  localparam int DSH    = $clog2(DWPL);
  localparam int ISH    = $clog2(IWPL);
  localparam int DAW    = $clog2(DWORDS);
  localparam int IAW    = $clog2(IWORDS);
  localparam int MAXWPL = (DWPL > IWPL) ? DWPL : IWPL;
  localparam int FCW    = $clog2(MAXWPL) + 1;
  localparam int CLRN   = (DWORDS > IWORDS) ? DWORDS : IWORDS;
  localparam int CLRW   = $clog2(CLRN) + 1;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_ISSUE   = 7'b0000100,
    ST_LOOK    = 7'b0001000,
    ST_WB_RD   = 7'b0010000,
    ST_WB_OUT  = 7'b0100000,
    ST_FILLREQ = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } dtag_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } itag_t;

  function automatic logic [DATA_W-1:0] sext_bytes(input logic [DATA_W-1:0] v,
                                                   input logic [1:0] sz);
    logic [DATA_W-1:0] r;
    unique case (sz)
      2'd0: r = {{56{v[7]}}, v[7:0]};
      2'd1: r = {{48{v[15]}}, v[15:0]};
      2'd2: r = {{32{v[31]}}, v[31:0]};
      2'd3: r = v;
    endcase
    return r;
  endfunction

  state_t            state_r, state_nxt;
  req_t              cur_r, cur_nxt;
  logic              pend_r, pend_nxt;
  logic [FCW-1:0]    fill_cnt_r, fill_cnt_nxt;
  logic [FCW-1:0]    wb_cnt_r, wb_cnt_nxt;
  logic [ADDR_W-1:0] wb_base_r, wb_base_nxt;
  logic              wb_ic_r, wb_ic_nxt;
  logic              wb_fill_r, wb_fill_nxt;
  logic [CLRW-1:0]   clr_cnt_r, clr_cnt_nxt;
  res_t              res_r, res_nxt;

  logic [DATA_W-1:0] dmem [DWORDS];
  logic [DATA_W-1:0] imem [IWORDS];
  dtag_t             dtag_mem [DCACHE_LINES];
  itag_t             itag_mem [ICACHE_LINES];

  logic              dmem_we, imem_we, dtag_we, itag_we;
  logic [DAW-1:0]    dmem_wa, dmem_ra;
  logic [IAW-1:0]    imem_wa, imem_ra;
  logic [DLW-1:0]    dtag_wa;
  logic [ILW-1:0]    itag_wa;
  logic [DATA_W-1:0] dmem_wd, imem_wd, dmem_rd_r, imem_rd_r;
  dtag_t             dtag_wd, dtag_rd_r;
  itag_t             itag_wd, itag_rd_r;

  req_t              rd_req;
  logic [ADDR_W-1:0] rd_line_addr, cur_line_addr;
  logic [DLW-1:0]    rd_dline, cur_dline;
  logic [ILW-1:0]    rd_iline, cur_iline;
  logic [DAW-1:0]    rd_dword, cur_dword, cur_dbase;
  logic [IAW-1:0]    rd_iword, cur_ibase;
  logic [TAG_W-1:0]  ptag;
  logic              d_hit, i_hit, pend_ic;
  logic [FCW-1:0]    pend_last, wb_last;
  logic [3:0]        nbytes;
  logic [2:0]        acc_off;
  logic [5:0]        lane_sh;
  logic [DATA_W-1:0] lane_mask, d_old, wr_val, new_word, fetch_val;

  assign rd_req        = (state_r == ST_IDLE) ? q_head : cur_r;
  assign rd_line_addr  = (rd_req.req_type == REQ_OP) ? rd_req.virt_addr : rd_req.phys_addr;
  assign rd_dline      = DLW'(rd_line_addr >> DOFFW);
  assign rd_iline      = ILW'(rd_line_addr >> IOFFW);
  assign rd_dword      = (DAW'(rd_dline) << DSH)
                       | (DAW'(rd_req.phys_addr >> 3) & DAW'(DWPL - 1));
  assign rd_iword      = (IAW'(rd_iline) << ISH)
                       | (IAW'(rd_req.phys_addr >> 3) & IAW'(IWPL - 1));

  assign cur_line_addr = (cur_r.req_type == REQ_OP) ? cur_r.virt_addr : cur_r.phys_addr;
  assign cur_dline     = DLW'(cur_line_addr >> DOFFW);
  assign cur_iline     = ILW'(cur_line_addr >> IOFFW);
  assign cur_dbase     = DAW'(cur_dline) << DSH;
  assign cur_ibase     = IAW'(cur_iline) << ISH;
  assign cur_dword     = cur_dbase | (DAW'(cur_r.phys_addr >> 3) & DAW'(DWPL - 1));

  assign dmem_ra = (state_r == ST_WB_RD) ? (cur_dbase | DAW'(wb_cnt_r)) : rd_dword;
  assign imem_ra = (state_r == ST_WB_RD) ? (cur_ibase | IAW'(wb_cnt_r)) : rd_iword;

  assign ptag      = cur_r.phys_addr[ADDR_W-1:12];
  assign d_hit     = dtag_rd_r.valid && (dtag_rd_r.tag == ptag);
  assign i_hit     = itag_rd_r.valid && (itag_rd_r.tag == ptag);
  assign pend_ic   = (cur_r.req_type != REQ_READ) && (cur_r.req_type != REQ_WRITE);
  assign pend_last = pend_ic ? FCW'(IWPL - 1) : FCW'(DWPL - 1);
  assign wb_last   = wb_ic_r ? FCW'(IWPL - 1) : FCW'(DWPL - 1);

  assign nbytes    = 4'd1 << cur_r.access_size;
  assign acc_off   = cur_r.phys_addr[2:0] & ~3'(nbytes - 4'd1);
  assign lane_sh   = 6'({4'd8 - {1'b0, acc_off} - nbytes, 3'b000});
  assign lane_mask = (nbytes == 4'd8) ? {DATA_W{1'b1}}
                   : ((64'd1 << {nbytes, 3'b000}) - 64'd1);
  assign d_old     = (dmem_rd_r >> lane_sh) & lane_mask;
  assign wr_val    = cur_r.mask_enable ? ((cur_r.wr_data & cur_r.wr_mask) | (d_old & ~cur_r.wr_mask))
                   : cur_r.wr_data;
  assign new_word  = (dmem_rd_r & ~(lane_mask << lane_sh)) | ((wr_val & lane_mask) << lane_sh);
  assign fetch_val = cur_r.phys_addr[2] ? {{32{imem_rd_r[31]}}, imem_rd_r[31:0]}
                   : {{32{imem_rd_r[63]}}, imem_rd_r[63:32]};

  assign clearing = (state_r == ST_CLEAR);
  assign res      = res_r;

  always_comb begin
    logic do_wb;
    logic wb_icache;
    logic give_done;

    do_wb        = 1'b0;
    wb_icache    = 1'b0;
    give_done    = 1'b0;
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    pend_nxt     = pend_r;
    fill_cnt_nxt = fill_cnt_r;
    wb_cnt_nxt   = wb_cnt_r;
    wb_base_nxt  = wb_base_r;
    wb_ic_nxt    = wb_ic_r;
    wb_fill_nxt  = wb_fill_r;
    clr_cnt_nxt  = clr_cnt_r;
    res_nxt      = '0;
    q_pop        = 1'b0;
    dmem_we      = 1'b0;
    dmem_wa      = cur_dword;
    dmem_wd      = '0;
    imem_we      = 1'b0;
    imem_wa      = cur_ibase;
    imem_wd      = '0;
    dtag_we      = 1'b0;
    dtag_wa      = cur_dline;
    dtag_wd      = '0;
    itag_we      = 1'b0;
    itag_wa      = cur_iline;
    itag_wd      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        dmem_we     = (clr_cnt_r < CLRW'(DWORDS));
        dmem_wa     = DAW'(clr_cnt_r);
        imem_we     = (clr_cnt_r < CLRW'(IWORDS));
        imem_wa     = IAW'(clr_cnt_r);
        dtag_we     = (clr_cnt_r < CLRW'(DCACHE_LINES));
        dtag_wa     = DLW'(clr_cnt_r);
        itag_we     = (clr_cnt_r < CLRW'(ICACHE_LINES));
        itag_wa     = ILW'(clr_cnt_r);
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLRW'(CLRN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (pend_r) begin
            if (q_head.req_type == REQ_FILL) begin
              if (pend_ic) begin
                imem_we = 1'b1;
                imem_wa = cur_ibase | IAW'(fill_cnt_r);
                imem_wd = q_head.wr_data;
              end else begin
                dmem_we = 1'b1;
                dmem_wa = cur_dbase | DAW'(fill_cnt_r);
                dmem_wd = q_head.wr_data;
              end
              if (fill_cnt_r == pend_last) begin
                fill_cnt_nxt = '0;
                pend_nxt     = 1'b0;
                if (pend_ic) begin
                  itag_we = 1'b1;
                  itag_wd = '{valid: 1'b1, tag: ptag};
                end else begin
                  dtag_we = 1'b1;
                  dtag_wd = '{valid: 1'b1, dirty: 1'b0, tag: ptag};
                end
                if (cur_r.req_type == REQ_OP) begin
                  res_nxt.strobe = 1'b1;
                  res_nxt.kind   = RES_DONE;
                  res_nxt.last   = 1'b1;
                end else begin
                  state_nxt = ST_ISSUE;
                end
              end else begin
                fill_cnt_nxt = fill_cnt_r + 1'b1;
              end
            end
          end else begin
            cur_nxt = q_head;
            if (q_head.req_type <= REQ_OP) begin
              state_nxt = ST_LOOK;
            end
          end
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
        unique case (cur_r.req_type)
          REQ_READ, REQ_WRITE: begin
            if (d_hit) begin
              res_nxt.strobe = 1'b1;
              res_nxt.last   = 1'b1;
              if (cur_r.req_type == REQ_READ) begin
                res_nxt.kind = RES_READ;
                res_nxt.data = sext_bytes(d_old, cur_r.access_size);
              end else begin
                res_nxt.kind = RES_DONE;
                dmem_we      = 1'b1;
                dmem_wd      = new_word;
                dtag_we      = 1'b1;
                dtag_wd      = '{valid: dtag_rd_r.valid, dirty: 1'b1, tag: dtag_rd_r.tag};
              end
            end else if (dtag_rd_r.valid && dtag_rd_r.dirty) begin
              do_wb       = 1'b1;
              wb_fill_nxt = 1'b1;
            end else begin
              state_nxt = ST_FILLREQ;
            end
          end
          REQ_FETCH: begin
            if (i_hit) begin
              res_nxt.strobe = 1'b1;
              res_nxt.kind   = RES_READ;
              res_nxt.data   = fetch_val;
              res_nxt.last   = 1'b1;
            end else begin
              state_nxt = ST_FILLREQ;
            end
          end
          default: begin
            if (cur_r.cache_select == SEL_DCACHE) begin
              unique case (cur_r.cache_op)
                OP_INDEX_INV: begin
                  do_wb   = dtag_rd_r.valid && dtag_rd_r.dirty;
                  dtag_we = 1'b1;
                  dtag_wd = '{valid: 1'b0, dirty: dtag_rd_r.dirty && !dtag_rd_r.valid,
                              tag: dtag_rd_r.tag};
                end
                OP_LOAD_TAG: begin
                  res_nxt.strobe = 1'b1;
                  res_nxt.kind   = RES_TAG;
                  res_nxt.tag    = dtag_rd_r.tag;
                  res_nxt.state  = {dtag_rd_r.valid, dtag_rd_r.dirty};
                  res_nxt.last   = 1'b1;
                end
                OP_STORE_TAG: begin
                  dtag_we = 1'b1;
                  dtag_wd = '{valid: cur_r.tag_state[1], dirty: cur_r.tag_state[0],
                              tag: cur_r.tag_value};
                end
                OP_CREATE_DIRTY: begin
                  do_wb   = dtag_rd_r.valid && dtag_rd_r.dirty && (dtag_rd_r.tag != ptag);
                  dtag_we = 1'b1;
                  dtag_wd = '{valid: 1'b1, dirty: 1'b1, tag: ptag};
                end
                OP_HIT_INV: begin
                  dtag_we = d_hit;
                  dtag_wd = '{valid: 1'b0, dirty: 1'b0, tag: dtag_rd_r.tag};
                end
                OP_HIT_WB_INV: begin
                  do_wb   = d_hit && dtag_rd_r.dirty;
                  dtag_we = d_hit;
                  dtag_wd = '{valid: 1'b0, dirty: 1'b0, tag: dtag_rd_r.tag};
                end
                OP_HIT_WB: begin
                  do_wb   = d_hit && dtag_rd_r.dirty;
                  dtag_we = do_wb;
                  dtag_wd = '{valid: dtag_rd_r.valid, dirty: 1'b0, tag: dtag_rd_r.tag};
                end
                default: begin
                end
              endcase
              give_done = !do_wb && (cur_r.cache_op != OP_LOAD_TAG);
            end else if (cur_r.cache_select == SEL_ICACHE) begin
              give_done = 1'b1;
              unique case (cur_r.cache_op)
                OP_INDEX_INV: begin
                  itag_we = 1'b1;
                  itag_wd = '{valid: 1'b0, tag: itag_rd_r.tag};
                end
                OP_LOAD_TAG: begin
                  give_done      = 1'b0;
                  res_nxt.strobe = 1'b1;
                  res_nxt.kind   = RES_TAG;
                  res_nxt.tag    = itag_rd_r.tag;
                  res_nxt.state  = {itag_rd_r.valid, 1'b0};
                  res_nxt.last   = 1'b1;
                end
                OP_STORE_TAG: begin
                  itag_we = 1'b1;
                  itag_wd = '{valid: cur_r.tag_state[1], tag: cur_r.tag_value};
                end
                OP_HIT_INV: begin
                  itag_we = i_hit;
                  itag_wd = '{valid: 1'b0, tag: itag_rd_r.tag};
                end
                OP_HIT_WB_INV: begin
                  give_done = 1'b0;
                  state_nxt = ST_FILLREQ;
                end
                OP_HIT_WB: begin
                  do_wb     = i_hit;
                  wb_icache = 1'b1;
                  give_done = !i_hit;
                end
                default: begin
                end
              endcase
            end else begin
              give_done = 1'b1;
            end
            wb_fill_nxt = 1'b0;
            if (give_done) begin
              res_nxt.strobe = 1'b1;
              res_nxt.kind   = RES_DONE;
              res_nxt.last   = 1'b1;
            end
          end
        endcase
        if (do_wb) begin
          state_nxt  = ST_WB_RD;
          wb_cnt_nxt = '0;
          wb_ic_nxt  = wb_icache;
          if (wb_icache) begin
            wb_base_nxt = {itag_rd_r.tag,
                           cur_r.phys_addr[11:0] & PAGE_OFF_MASK & ~12'(ILINE_BYTES - 1)};
          end else begin
            wb_base_nxt = {dtag_rd_r.tag,
                           cur_r.phys_addr[11:0] & PAGE_OFF_MASK & ~12'(DLINE_BYTES - 1)};
          end
        end
      end
      ST_WB_RD: begin
        state_nxt = ST_WB_OUT;
      end
      ST_WB_OUT: begin
        res_nxt.strobe = 1'b1;
        res_nxt.kind   = RES_WB_WORD;
        res_nxt.addr   = wb_base_r + (ADDR_W'(wb_cnt_r) << 3);
        res_nxt.data   = wb_ic_r ? imem_rd_r : dmem_rd_r;
        if (wb_cnt_r == wb_last) begin
          res_nxt.last = !wb_fill_r;
          state_nxt    = wb_fill_r ? ST_FILLREQ : ST_IDLE;
        end else begin
          wb_cnt_nxt = wb_cnt_r + 1'b1;
          state_nxt  = ST_WB_RD;
        end
      end
      ST_FILLREQ: begin
        res_nxt.strobe = 1'b1;
        res_nxt.kind   = RES_FILL_REQ;
        res_nxt.addr   = pend_ic ? (cur_r.phys_addr & ~ADDR_W'(ILINE_BYTES - 1))
                       : (cur_r.phys_addr & ~ADDR_W'(DLINE_BYTES - 1));
        res_nxt.last   = 1'b1;
        pend_nxt       = 1'b1;
        fill_cnt_nxt   = '0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_wa] <= dmem_wd;
    end
    dmem_rd_r <= dmem[dmem_ra];
  end

  always_ff @(posedge clk) begin
    if (imem_we) begin
      imem[imem_wa] <= imem_wd;
    end
    imem_rd_r <= imem[imem_ra];
  end

  always_ff @(posedge clk) begin
    if (dtag_we) begin
      dtag_mem[dtag_wa] <= dtag_wd;
    end
    dtag_rd_r <= dtag_mem[rd_dline];
  end

  always_ff @(posedge clk) begin
    if (itag_we) begin
      itag_mem[itag_wa] <= itag_wd;
    end
    itag_rd_r <= itag_mem[rd_iline];
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    wb_cnt_r  <= wb_cnt_nxt;
    wb_base_r <= wb_base_nxt;
    wb_ic_r   <= wb_ic_nxt;
    wb_fill_r <= wb_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      pend_r     <= 1'b0;
      fill_cnt_r <= '0;
      clr_cnt_r  <= '0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_r     <= pend_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      res_r      <= res_nxt;
    end
  end

  a_pend_waits_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_IDLE)
    else $error("A miss is pending while the engine is not idle.");

  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !res_r.strobe)
    else $error("A result was issued during the clearing pass.");

  a_fill_req_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.strobe && res_r.kind == RES_FILL_REQ |-> res_r.last && pend_r)
    else $error("A fill request was not final or left no pending miss.");

  a_fill_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> fill_cnt_r <= pend_last)
    else $error("The fill word count ran past the line.");

  a_wb_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB_RD |=> state_r == ST_WB_OUT && res_r.strobe == 1'b0)
    else $error("A writeback word read did not lead to its output step.");

endmodule
